// ===== hdl/gcd_ratio_reducer_assert.svh =====
// assertion macros used by the checker file
`ifndef GCD_RATIO_REDUCER_ASSERT_SVH
`define GCD_RATIO_REDUCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd_ratio_reducer: same-cycle check failed");

// next-cycle implication, disabled during reset
`define GRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcd_ratio_reducer: next-cycle check failed");

`endif

// ===== hdl/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// Types, constants and the microcode table of the gcd ratio reducer.
// ----------------------------------------------------------------------------
package grr_pkg;

  // width of the counts and the numeric results
  localparam int unsigned COUNT_WIDTH = 16;
  // divider bit counter must hold COUNT_WIDTH itself
  localparam int unsigned CNT_W = $clog2(COUNT_WIDTH + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CNT_W-1:0]       bitcnt_t;
  typedef logic [3:0]             upc_t;

  // input transaction
  typedef struct packed {
    count_t count_a;
    count_t count_b;
  } in_t;

  // output transaction
  typedef struct packed {
    count_t divisor;
    count_t quotient_a;
    count_t quotient_b;
    logic   zero_error;
  } out_t;

  // divider operand selection
  typedef enum logic [1:0] {
    DSEL_XY,  // x / y, one euclid step
    DSEL_AG,  // a / gcd
    DSEL_BG   // b / gcd
  } dsel_e;

  // register write selection
  typedef enum logic [1:0] {
    WR_NONE,
    WR_XY,    // x <= y, y <= remainder
    WR_QA,    // quotient a <= divider quotient
    WR_QB     // quotient b <= divider quotient
  } wsel_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEXT,      // never jump
    COND_ALWAYS,
    COND_NO_IN,     // no input transaction this cycle
    COND_ERR,       // a count was zero
    COND_DIV_BUSY,
    COND_Y_NZ,      // euclid remainder still nonzero
    COND_OUT_FULL   // output register cannot take a new result
  } cond_e;

  // one microcode word
  typedef struct packed {
    logic  take_in;
    logic  div_start;
    dsel_e dsel;
    wsel_e wsel;
    logic  out_load;
    cond_e cond;
    upc_t  target;
  } ctl_t;

  // program addresses
  localparam upc_t StepFetch   = 4'd0;
  localparam upc_t StepCheck   = 4'd1;
  localparam upc_t StepDivXy   = 4'd2;
  localparam upc_t StepWaitXy  = 4'd3;
  localparam upc_t StepSwap    = 4'd4;
  localparam upc_t StepLoop    = 4'd5;
  localparam upc_t StepDivAg   = 4'd6;
  localparam upc_t StepWaitAg  = 4'd7;
  localparam upc_t StepSaveQa  = 4'd8;
  localparam upc_t StepDivBg   = 4'd9;
  localparam upc_t StepWaitBg  = 4'd10;
  localparam upc_t StepSaveQb  = 4'd11;
  localparam upc_t StepEmit    = 4'd12;
  localparam upc_t StepRestart = 4'd13;

  // control store
  function automatic ctl_t ucode(upc_t pc);
    ctl_t cw;
    cw = '0;
    case (pc)
      StepFetch: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NO_IN;
        cw.target  = StepFetch;
      end
      StepCheck: begin
        cw.cond   = COND_ERR;
        cw.target = StepEmit;
      end
      StepDivXy: begin
        cw.div_start = 1'b1;
        cw.dsel      = DSEL_XY;
      end
      StepWaitXy: begin
        cw.cond   = COND_DIV_BUSY;
        cw.target = StepWaitXy;
      end
      StepSwap: begin
        cw.wsel = WR_XY;
      end
      StepLoop: begin
        cw.cond   = COND_Y_NZ;
        cw.target = StepDivXy;
      end
      StepDivAg: begin
        cw.div_start = 1'b1;
        cw.dsel      = DSEL_AG;
      end
      StepWaitAg: begin
        cw.cond   = COND_DIV_BUSY;
        cw.target = StepWaitAg;
      end
      StepSaveQa: begin
        cw.wsel = WR_QA;
      end
      StepDivBg: begin
        cw.div_start = 1'b1;
        cw.dsel      = DSEL_BG;
      end
      StepWaitBg: begin
        cw.cond   = COND_DIV_BUSY;
        cw.target = StepWaitBg;
      end
      StepSaveQb: begin
        cw.wsel = WR_QB;
      end
      StepEmit: begin
        cw.out_load = 1'b1;
        cw.cond     = COND_OUT_FULL;
        cw.target   = StepEmit;
      end
      StepRestart: begin
        cw.cond   = COND_ALWAYS;
        cw.target = StepFetch;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = StepFetch;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/gcd_ratio_reducer.sv =====
// Reduces a pair of unsigned counts to lowest terms: returns their greatest
// common divisor and each count divided by it, or zeros with zero_error set
// when either count is zero. One transaction is processed at a time; a
// finished result waits in an output register while the next input is
// taken. Work is done by one restoring divider (one quotient bit per cycle)
// driven by a microcode sequencer. The error path skips the divider;
// otherwise the divider runs once for each of the k Euclid remainder steps
// (k is at most 23 for 16-bit counts) and then once
// each for the two quotients.
// ----------------------------------------------------------------------------
// gcd_ratio_reducer
// Microcoded gcd and ratio reduction over a shared bit-serial divider.
// ----------------------------------------------------------------------------
module gcd_ratio_reducer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  grr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output grr_pkg::out_t out_data_o
);
  import grr_pkg::*;

  localparam int unsigned W = COUNT_WIDTH;

  // sequencer
  upc_t upc_q, upc_d;
  ctl_t cw;
  logic jump;

  // datapath registers
  count_t a_q, b_q, x_q, y_q, qa_q, qb_q;
  logic   err_q;

  // divider
  count_t  rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  bitcnt_t cnt_q, cnt_d;
  logic    div_busy;
  logic [W:0] div_trial, div_diff;
  logic       div_ge;
  count_t     div_dividend, div_divisor;

  // output register
  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic out_full, in_fire, out_fire;

  assign cw         = ucode(upc_q);
  assign in_stall_o = ~cw.take_in;
  assign in_fire    = in_valid_i & cw.take_in;
  assign out_full   = out_valid_q & out_stall_i;
  assign out_fire   = cw.out_load & ~out_full;
  assign div_busy   = (cnt_q != '0);

  // jump condition
  always_comb begin
    case (cw.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = ~in_valid_i;
      COND_ERR:      jump = err_q;
      COND_DIV_BUSY: jump = div_busy;
      COND_Y_NZ:     jump = (y_q != '0);
      COND_OUT_FULL: jump = out_full;
      default:       jump = 1'b0;
    endcase
  end

  // next program address
  always_comb begin
    upc_d = jump ? cw.target : upc_q + 4'd1;
  end

  // divider operand selection
  always_comb begin
    case (cw.dsel)
      DSEL_XY: begin
        div_dividend = x_q;
        div_divisor  = y_q;
      end
      DSEL_AG: begin
        div_dividend = a_q;
        div_divisor  = x_q;
      end
      DSEL_BG: begin
        div_dividend = b_q;
        div_divisor  = x_q;
      end
      default: begin
        div_dividend = x_q;
        div_divisor  = y_q;
      end
    endcase
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    div_trial = {rem_q, quo_q[W-1]};
    div_ge    = (div_trial >= {1'b0, dvs_q});
    div_diff  = div_trial - {1'b0, dvs_q};
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    cnt_d     = cnt_q;
    if (cw.div_start) begin
      rem_d = '0;
      quo_d = div_dividend;
      dvs_d = div_divisor;
      cnt_d = CNT_W'(W);
    end else if (div_busy) begin
      rem_d = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
      quo_d = {quo_q[W-2:0], div_ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // output register next valid
  always_comb begin
    if (out_fire) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= StepFetch;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    if (in_fire) begin
      a_q   <= in_data_i.count_a;
      b_q   <= in_data_i.count_b;
      x_q   <= in_data_i.count_a;
      y_q   <= in_data_i.count_b;
      err_q <= (in_data_i.count_a == '0) | (in_data_i.count_b == '0);
    end
    case (cw.wsel)
      WR_XY: begin
        x_q <= y_q;
        y_q <= rem_q;
      end
      WR_QA:   qa_q <= quo_q;
      WR_QB:   qb_q <= quo_q;
      default: ;
    endcase
    if (out_fire) begin
      out_q.divisor    <= err_q ? '0 : x_q;
      out_q.quotient_a <= err_q ? '0 : qa_q;
      out_q.quotient_b <= err_q ? '0 : qb_q;
      out_q.zero_error <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/grr_checker.sv =====
// ----------------------------------------------------------------------------
// grr_checker
// Port-level checks of the gcd ratio reducer, bound to the top level.
// ----------------------------------------------------------------------------
`include "gcd_ratio_reducer_assert.svh"

module grr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input grr_pkg::out_t out_data_o
);
  import grr_pkg::*;

  logic in_fire;
  logic out_wait;
  logic res_zero;
  logic res_nonzero;

  assign in_fire  = in_valid_i & ~in_stall_o;
  assign out_wait = out_valid_o & out_stall_i;

  // numeric result fields all zero, or all nonzero
  assign res_zero    = (out_data_o.divisor == '0) && (out_data_o.quotient_a == '0) &&
                       (out_data_o.quotient_b == '0);
  assign res_nonzero = (out_data_o.divisor != '0) && (out_data_o.quotient_a != '0) &&
                       (out_data_o.quotient_b != '0);

  // a stalled result transaction stays and holds its payload
  `GRR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o))

  // error results carry zeros
  `GRR_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.zero_error, res_zero)

  // good results are never zero
  `GRR_ASSERT_NOW(a_ok_nonzero, clk_i, rst_ni, out_valid_o && !out_data_o.zero_error, res_nonzero)

  // after it takes a transaction, the block stalls its input
  `GRR_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_fire, in_stall_o)

endmodule

bind gcd_ratio_reducer grr_checker u_grr_checker (.*);

// ===== test/gcd_ratio_reducer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_ratio_reducer_test
// Self-checking bench for the gcd ratio reducer. Count pairs go in through
// the valid/stall input channel with random gaps. Each result is compared
// field by field against a Euclid-based prediction of gcd and reduced ratio.
// The output side stalls at random.
// ----------------------------------------------------------------------------

// expected reductions in arrival order, plus the mismatch count
class ratio_scoreboard;
  grr_pkg::out_t reductions[$];
  int unsigned   errors;

  function new();
    errors = 0;
  endfunction

  // lowest-terms reduction of one count pair
  function grr_pkg::out_t reduce_pair(grr_pkg::in_t pair);
    grr_pkg::out_t  res;
    grr_pkg::count_t x;
    grr_pkg::count_t y;
    grr_pkg::count_t r;
    res = '0;
    if (pair.count_a == '0 || pair.count_b == '0) begin
      res.zero_error = 1'b1;
    end else begin
      x = pair.count_a;
      y = pair.count_b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor    = x;
      res.quotient_a = pair.count_a / x;
      res.quotient_b = pair.count_b / x;
    end
    return res;
  endfunction

  task report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    errors++;
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
  endtask

  // accepted input transaction
  function void note_input(grr_pkg::in_t pair);
    reductions.push_back(reduce_pair(pair));
  endfunction

  // accepted output transaction
  task check_result(grr_pkg::out_t got);
    grr_pkg::out_t exp_r;
    if (reductions.size() == 0) begin
      report_mismatch("unexpected result", 0, got);
    end else begin
      exp_r = reductions.pop_front();
      if (got.divisor !== exp_r.divisor)
        report_mismatch("divisor", exp_r.divisor, got.divisor);
      if (got.quotient_a !== exp_r.quotient_a)
        report_mismatch("quotient_a", exp_r.quotient_a, got.quotient_a);
      if (got.quotient_b !== exp_r.quotient_b)
        report_mismatch("quotient_b", exp_r.quotient_b, got.quotient_b);
      if (got.zero_error !== exp_r.zero_error)
        report_mismatch("zero_error", exp_r.zero_error, got.zero_error);
    end
  endtask
endclass

module gcd_ratio_reducer_test;

  localparam int unsigned RANDOM_ITEMS = 930;
  // no-progress limit: worst euclid chain plus the longest gaps, with margin
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 600;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall;
  grr_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  grr_pkg::out_t out_data;

  ratio_scoreboard sb;
  bit              quiet;
  int unsigned     idle_cycles;

  gcd_ratio_reducer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // one input transaction, optionally preceded by an idle gap
  task automatic send_pair(grr_pkg::count_t a, grr_pkg::count_t b);
    int unsigned  gap;
    grr_pkg::in_t pair;
    gap = pick_gap();
    pair.count_a = a;
    pair.count_b = b;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(pair);
  endtask

  // random pair with a bias toward shared factors and long euclid chains
  task automatic send_random_pair();
    int unsigned kind;
    int unsigned g;
    int unsigned a;
    int unsigned b;
    int unsigned f0;
    int unsigned f1;
    int unsigned t;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      a = (kind < 2) ? 0 : $urandom_range(0, 65535);
      b = (kind >= 2 && kind < 4) ? 0 : $urandom_range(0, 65535);
      if (kind == 4) a = 0;
    end else if (kind < 40) begin
      a = $urandom_range(0, 65535);
      b = $urandom_range(0, 65535);
    end else if (kind < 65) begin
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 8191) : $urandom_range(1, 255);
      a = g * $urandom_range(1, 65535 / g);
      b = g * $urandom_range(1, 65535 / g);
    end else if (kind < 78) begin
      a = $urandom_range(1, 64);
      b = $urandom_range(1, 64);
    end else if (kind < 86) begin
      // adjacent fibonacci numbers, scaled
      f0 = 1;
      f1 = 1;
      n  = $urandom_range(2, 22);
      repeat (n) begin
        t  = f0 + f1;
        f0 = f1;
        f1 = t;
      end
      g = $urandom_range(1, 65535 / f1);
      a = f1 * g;
      b = f0 * g;
      if ($urandom_range(0, 1)) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (kind < 93) begin
      a = 1 << $urandom_range(0, 15);
      b = $urandom_range(1, 65535);
    end else begin
      a = $urandom_range(1, 4095);
      b = ($urandom_range(0, 1)) ? a : a * $urandom_range(1, 65535 / a);
    end
    send_pair(a[15:0], b[15:0]);
  endtask

  // receiver: open stretches broken by stalls of random length
  initial begin : out_stall_driver
    int unsigned open_len;
    int unsigned hold_len;
    out_stall = 1'b0;
    forever begin
      open_len = $urandom_range(1, 30);
      @(negedge clk_i);
      out_stall <= 1'b0;
      repeat (open_len - 1) @(negedge clk_i);
      hold_len = pick_gap();
      if (hold_len > 0) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (hold_len - 1) @(negedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("gcd_ratio_reducer test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // main sequence
  initial begin
    sb          = new();
    quiet       = 1'b1;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero counts, extremes, long euclid chains, simple ratios
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h0000, 16'h1234);
    send_pair(16'hffff, 16'h0000);
    send_pair(16'h0000, 16'hffff);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'hffff, 16'hffff);
    send_pair(16'h0001, 16'hffff);
    send_pair(16'hffff, 16'h0001);
    send_pair(16'hffff, 16'hfffe);
    send_pair(16'd46368, 16'd28657);
    send_pair(16'd28657, 16'd46368);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h4000);
    send_pair(16'haaaa, 16'h5555);
    send_pair(16'h5555, 16'haaaa);
    send_pair(16'd60, 16'd48);
    send_pair(16'd65521, 16'd65519);
    send_pair(16'd3, 16'd65535);
    send_pair(16'd65280, 16'd255);
    send_pair(16'd2, 16'd1);

    // random part, with quiet stretches in between
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i % 300) < 60;
      send_random_pair();
    end
    quiet = 1'b0;
    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain
    while (sb.reductions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("gcd_ratio_reducer test passed");
    end else begin
      $display("gcd_ratio_reducer test failed");
    end
    $finish;
  end

endmodule
